### rtl/core/clsr_pkg.sv
// ----------------------------------------------------------------------------
// clsr_pkg - shared constants and types for the combined lcg shuffle rng
// Widths, generator constants and request codes used across the core.
// ----------------------------------------------------------------------------
package clsr_pkg;

    localparam int VAL_W   = 31;
    localparam int SEED_W  = 32;
    localparam int MUL_W   = 16;
    localparam int DELTA_W = 8;

    // moduli are 2^31 - DELTA
    localparam logic [MUL_W-1:0]   MUL_A   = 16'd40014;
    localparam logic [MUL_W-1:0]   MUL_B   = 16'd40692;
    localparam logic [DELTA_W-1:0] DELTA_A = 8'd85;
    localparam logic [DELTA_W-1:0] DELTA_B = 8'd249;

    localparam longint MOD_A   = 64'd2147483563;
    localparam longint OUT_TOP = MOD_A - 64'd1;

    localparam logic [VAL_W-1:0] SEED_B_RESET = 31'd123456789;

    localparam int DEF_TABLE_DEPTH = 32;
    localparam int WARM_EXTRA      = 8;
    localparam int RECIP_SHIFT     = 40;

    typedef logic [VAL_W-1:0] value_t;

    typedef enum logic {
        CMD_DRAW = 1'b0,
        CMD_SEED = 1'b1
    } cmd_t;

endpackage

### rtl/core/clsr_mulmod.sv
// ----------------------------------------------------------------------------
// clsr_mulmod - constant modular multiplier
// y = x * MUL mod (2^31 - DELTA), two register stages, free running.
// ----------------------------------------------------------------------------
module clsr_mulmod #(
    parameter logic [clsr_pkg::MUL_W-1:0]   MUL   = clsr_pkg::MUL_A,
    parameter logic [clsr_pkg::DELTA_W-1:0] DELTA = clsr_pkg::DELTA_A
) (
    input  logic            aclk,
    input  clsr_pkg::value_t x,
    output clsr_pkg::value_t y
);
    import clsr_pkg::*;

    localparam int PROD_W = VAL_W + MUL_W;
    localparam logic [VAL_W:0] MODULUS = (VAL_W + 1)'((64'd1 << VAL_W) - 64'(DELTA));

    logic [PROD_W-1:0]        prod_reg;
    value_t                   y_reg;
    logic [MUL_W-1:0]         hi;
    value_t                   lo;
    logic [MUL_W+DELTA_W-1:0] hi_fold;
    logic [VAL_W:0]           fold;

    // 2^31 is congruent to DELTA, so the top bits fold back in
    always_comb begin
        hi      = prod_reg[PROD_W-1 -: MUL_W];
        lo      = prod_reg[VAL_W-1:0];
        hi_fold = (MUL_W + DELTA_W)'(hi) * (MUL_W + DELTA_W)'(DELTA);
        fold    = {1'b0, lo} + (VAL_W + 1)'(hi_fold);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(x) * PROD_W'(MUL);
        y_reg    <= (fold >= MODULUS) ? VAL_W'(fold - MODULUS) : fold[VAL_W-1:0];
    end

    assign y = y_reg;

endmodule

### rtl/core/clsr_slot.sv
// ----------------------------------------------------------------------------
// clsr_slot - shuffle slot index from the previous output
// slot = value / SLOT_DIV by reciprocal multiply, one correction step, clamp.
// ----------------------------------------------------------------------------
module clsr_slot #(
    parameter int TABLE_DEPTH = clsr_pkg::DEF_TABLE_DEPTH
) (
    input  logic                           aclk,
    input  clsr_pkg::value_t               value,
    output logic [$clog2(TABLE_DEPTH)-1:0] slot
);
    import clsr_pkg::*;

    localparam int     AW       = $clog2(TABLE_DEPTH);
    localparam longint SLOT_DIV = 64'd1 + OUT_TOP / longint'(TABLE_DEPTH);
    localparam longint RECIP    = (64'd1 << RECIP_SHIFT) / SLOT_DIV;
    localparam int     RECIP_W  = $clog2(RECIP + 1);
    localparam int     DIV_W    = $clog2(SLOT_DIV + 1);
    localparam int     QW       = AW + 2;
    localparam int     RP_W     = VAL_W + RECIP_W;
    localparam int     BW       = QW + DIV_W;

    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [DIV_W-1:0]   DIV_C   = DIV_W'(SLOT_DIV);

    logic [RP_W-1:0] rprod;
    logic [QW-1:0]   q0_reg;
    value_t          value_reg;
    logic [QW-1:0]   q1;
    logic [BW-1:0]   bound;
    logic [QW-1:0]   qc;
    logic [AW-1:0]   slot_reg;

    assign rprod = RP_W'(value) * RP_W'(RECIP_C);

    // the estimate is low by at most one
    always_comb begin
        q1    = q0_reg + QW'(1);
        bound = BW'(q1) * BW'(DIV_C);
        qc    = (bound <= BW'(value_reg)) ? q1 : q0_reg;
    end

    always_ff @(posedge aclk) begin
        value_reg <= value;
        q0_reg    <= QW'(rprod >> RECIP_SHIFT);
        slot_reg  <= (qc >= QW'(TABLE_DEPTH)) ? AW'(TABLE_DEPTH - 1) : qc[AW-1:0];
    end

    assign slot = slot_reg;

endmodule

### rtl/core/clsr_table.sv
// ----------------------------------------------------------------------------
// clsr_table - shuffle table memory
// One write and one registered read port; per-entry valid bits make unwritten
// entries read as zero after reset.
// ----------------------------------------------------------------------------
module clsr_table #(
    parameter int TABLE_DEPTH = clsr_pkg::DEF_TABLE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    output clsr_pkg::value_t               rd_data,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  clsr_pkg::value_t               wr_data
);
    import clsr_pkg::*;

    value_t                   mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]   valid_reg;
    value_t                   rd_data_reg;
    logic                     rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

### rtl/core/combined_lcg_shuffle_rng_core.sv
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_core - combined lcg random generator with shuffle
// Two congruential generators combined through a shuffle table; a draw
// request returns one value, a seed request stores the seed.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                  | tuser
//  s_      | in  | [31:0] seed_value      | [0] command (0 draw, 1 seed)
//  m_      | out | [30:0] random_value    | -
//
//  draw: S_WAIT, S_READ and S_DONE lie between request and next accept, set by the two-stage
//  multipliers and the registered table read-modify-write; s_tready stays low meanwhile
//  first draw after a zero or negative seed adds a warm-up, S_WARM0 to S_WARM2
//  per step and then S_LAUNCH, one multiplier pass per step
//  seed request: stays in S_IDLE, no result
//  reset clears table valid bits at once, no clearing pass; a finished draw
//  waits in place while the previous result is still held on m_
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng_core #(
    parameter int TABLE_DEPTH = clsr_pkg::DEF_TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed_value
    input  logic [0:0]  s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [30:0] random_value, [31] zero
);
    import clsr_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + WARM_EXTRA);
    localparam value_t OUT_TOP_V = VAL_W'(OUT_TOP);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WARM0,
        S_WARM1,
        S_WARM2,
        S_LAUNCH,
        S_WAIT,
        S_READ,
        S_DONE
    } state_t;

    state_t                    state_reg;
    logic signed [SEED_W-1:0]  first_gen_reg;
    value_t                    second_gen_reg;
    value_t                    last_out_reg;
    logic [CW-1:0]             count_reg;
    logic [AW-1:0]             slot_reg;
    logic                      m_tvalid_reg;
    value_t                    m_tdata_reg;

    value_t          gen_a_y;
    value_t          gen_b_y;
    logic [AW-1:0]   slot_calc;
    value_t          tbl_rd_data;
    logic            tbl_rd_en;
    logic            tbl_wr_en;
    logic [AW-1:0]   tbl_wr_addr;
    value_t          tbl_wr_data;

    logic            s_accept;
    logic            commit;
    logic            needs_warm;
    value_t          seed_mag;
    logic signed [VAL_W+1:0] diff;
    logic signed [VAL_W+1:0] diff_wrap;
    value_t          out_value_next;

    clsr_mulmod #(
        .MUL   (MUL_A),
        .DELTA (DELTA_A)
    ) u_gen_a (
        .aclk (aclk),
        .x    (first_gen_reg[VAL_W-1:0]),
        .y    (gen_a_y)
    );

    clsr_mulmod #(
        .MUL   (MUL_B),
        .DELTA (DELTA_B)
    ) u_gen_b (
        .aclk (aclk),
        .x    (second_gen_reg),
        .y    (gen_b_y)
    );

    clsr_slot #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_slot (
        .aclk  (aclk),
        .value (last_out_reg),
        .slot  (slot_calc)
    );

    clsr_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_tbl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (tbl_rd_en),
        .rd_addr (slot_calc),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign commit   = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // zero or negative seed triggers warm-up; zero counts as one
    always_comb begin
        needs_warm = first_gen_reg[SEED_W-1] || (first_gen_reg == '0);
        if (first_gen_reg == '0) begin
            seed_mag = VAL_W'(1);
        end else if (first_gen_reg == {1'b1, {(SEED_W-1){1'b0}}}) begin
            seed_mag = '1;
        end else begin
            seed_mag = VAL_W'(-first_gen_reg);
        end
    end

    always_comb begin
        diff      = $signed({2'b00, tbl_rd_data}) - $signed({2'b00, second_gen_reg});
        diff_wrap = diff + $signed({2'b00, OUT_TOP_V});
        out_value_next = (diff < 1) ? diff_wrap[VAL_W-1:0] : diff[VAL_W-1:0];
    end

    always_comb begin
        tbl_rd_en   = (state_reg == S_READ);
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = slot_reg;
        tbl_wr_data = first_gen_reg[VAL_W-1:0];
        if (state_reg == S_WARM2 && count_reg < CW'(TABLE_DEPTH)) begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = count_reg[AW-1:0];
            tbl_wr_data = gen_a_y;
        end else if (commit) begin
            tbl_wr_en   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            first_gen_reg  <= '0;
            second_gen_reg <= SEED_B_RESET;
            last_out_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !commit) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (s_tuser[0] == CMD_SEED) begin
                            first_gen_reg <= $signed(s_tdata);
                        end else if (needs_warm) begin
                            first_gen_reg  <= $signed({1'b0, seed_mag});
                            second_gen_reg <= seed_mag;
                            count_reg      <= CW'(TABLE_DEPTH + WARM_EXTRA - 1);
                            state_reg      <= S_WARM0;
                        end else begin
                            state_reg <= S_WAIT;
                        end
                    end
                end
                S_WARM0: state_reg <= S_WARM1;
                S_WARM1: state_reg <= S_WARM2;
                S_WARM2: begin
                    first_gen_reg <= $signed({1'b0, gen_a_y});
                    if (count_reg == '0) begin
                        last_out_reg <= gen_a_y;
                        state_reg    <= S_LAUNCH;
                    end else begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_WARM0;
                    end
                end
                S_LAUNCH: state_reg <= S_WAIT;
                S_WAIT:   state_reg <= S_READ;
                S_READ: begin
                    first_gen_reg  <= $signed({1'b0, gen_a_y});
                    second_gen_reg <= gen_b_y;
                    slot_reg       <= slot_calc;
                    state_reg      <= S_DONE;
                end
                S_DONE: begin
                    if (commit) begin
                        last_out_reg <= out_value_next;
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= out_value_next;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_tdata_reg};

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[VAL_W-1:0] != '0 && m_tdata[VAL_W-1:0] <= OUT_TOP_V))
        else $error("result outside generator range");

    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside draw completion");

    a_seed_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser[0] == CMD_SEED) |=>
            (state_reg == S_IDLE && !$rose(m_tvalid_reg)))
        else $error("seed request produced work or a result");

    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> (slot_calc <= AW'(TABLE_DEPTH - 1)))
        else $error("shuffle slot beyond table");

    a_warm_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WARM2 && count_reg == '0) |=>
            (last_out_reg == first_gen_reg[VAL_W-1:0]))
        else $error("warm-up did not seed last output from slot zero");

endmodule
